// File: sv/dmc_pkg.sv
// shared constants, request type and helpers for the direct-mapped write-back cache
package dmc_pkg;

    localparam int ADDR_W      = 11;
    localparam int DATA_W      = 8;
    localparam int TAG_W       = 3;
    localparam int LINE_W      = 4;
    localparam int OFF_W       = 4;
    localparam int BYTE_SH_W   = 3;
    localparam int NUM_LINES   = 1 << LINE_W;
    localparam int BLOCK_BYTES = 1 << OFF_W;
    localparam int BLOCK_W     = BLOCK_BYTES * DATA_W;
    localparam int MEM_BLK_W   = TAG_W + LINE_W;
    localparam int MEM_BLOCKS  = 1 << MEM_BLK_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef logic [BLOCK_W-1:0] block_t;

    typedef struct packed {
        logic              op;
        logic [TAG_W-1:0]  tag;
        logic [LINE_W-1:0] line;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] wdata;
    } req_t;

    typedef struct packed {
        logic                 rd;
        logic [MEM_BLK_W-1:0] rd_blk;
        logic                 wr;
        logic [MEM_BLK_W-1:0] wr_blk;
        block_t               wdata;
    } mem_req_t;

    // contents of a block that has never been written back: each byte is its address mod 256
    function automatic block_t reset_block(input logic [MEM_BLK_W-1:0] blk);
        block_t            r;
        logic [ADDR_W-1:0] a;
        for (int i = 0; i < BLOCK_BYTES; i++)
        begin
            a = {blk, OFF_W'(i)};
            r[i*DATA_W +: DATA_W] = a[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: sv/dmc_channel_if.sv
// request and response channel interfaces
interface dmc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [dmc_pkg::ADDR_W-1:0] address;
    logic [dmc_pkg::DATA_W-1:0] write_data;

    modport source (output valid, output op, output address, output write_data, input ready);
    modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

interface dmc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [dmc_pkg::DATA_W-1:0] read_data;
    logic                       hit;

    modport source (output valid, output read_data, output hit, input ready);
    modport sink   (input valid, input read_data, input hit, output ready);
endinterface

// File: sv/dmc_front.sv
// request front end: accepts beats, splits the address and queues decoded requests
module dmc_front (
    input  logic           clk,
    input  logic           rst_n,
    dmc_req_if.sink        req,
    output dmc_pkg::req_t  head,
    output logic           head_valid,
    input  logic           pop
);

    dmc_pkg::req_t q_reg [dmc_pkg::QUEUE_DEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    dmc_pkg::req_t dec;

    assign req.ready  = (count_reg != 2'(dmc_pkg::QUEUE_DEPTH));
    assign push       = req.valid && req.ready;
    assign head       = q_reg[rd_ptr_reg];
    assign head_valid = (count_reg != 2'd0);

    always_comb
    begin
        dec.op     = req.op;
        dec.tag    = req.address[dmc_pkg::ADDR_W-1 -: dmc_pkg::TAG_W];
        dec.line   = req.address[dmc_pkg::OFF_W +: dmc_pkg::LINE_W];
        dec.offset = req.address[dmc_pkg::OFF_W-1:0];
        dec.wdata  = (req.op == dmc_pkg::OP_WRITE) ? req.write_data : '0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: sv/dmc_mem.sv
// backing memory, one block per row, rows never written read back as their reset pattern
module dmc_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  dmc_pkg::mem_req_t mreq,
    output dmc_pkg::block_t   rdata
);

    dmc_pkg::block_t                mem_reg [dmc_pkg::MEM_BLOCKS];
    logic [dmc_pkg::MEM_BLOCKS-1:0] row_valid_reg;
    dmc_pkg::block_t                rd_raw_reg;
    logic                           rd_valid_reg;
    logic [dmc_pkg::MEM_BLK_W-1:0]  rd_blk_reg;

    assign rdata = rd_valid_reg ? rd_raw_reg : dmc_pkg::reset_block(rd_blk_reg);

    always_ff @(posedge clk)
    begin
        if (mreq.wr)
        begin
            mem_reg[mreq.wr_blk] <= mreq.wdata;
        end
        if (mreq.rd)
        begin
            rd_raw_reg <= mem_reg[mreq.rd_blk];
            rd_blk_reg <= mreq.rd_blk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mreq.wr)
            begin
                row_valid_reg[mreq.wr_blk] <= 1'b1;
            end
            if (mreq.rd)
            begin
                rd_valid_reg <= row_valid_reg[mreq.rd_blk];
            end
        end
    end

endmodule

// File: sv/dmc_back.sv
// cache back end: tag lookup, victim write-back, refill, byte access and response register
module dmc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  dmc_pkg::req_t      head,
    input  logic               head_valid,
    output logic               pop,
    output dmc_pkg::mem_req_t  mreq,
    input  dmc_pkg::block_t    mem_rdata,
    dmc_rsp_if.source          rsp
);

    typedef enum logic {S_IDLE, S_EXEC} state_t;

    localparam int BIDX_W = dmc_pkg::OFF_W + dmc_pkg::BYTE_SH_W;

    state_t                          state_reg;
    dmc_pkg::req_t                   cur_reg;
    logic                            hit_reg;
    logic                            victim_dirty_reg;
    logic [dmc_pkg::TAG_W-1:0]       victim_tag_reg;
    logic                            out_valid_reg;
    logic [dmc_pkg::DATA_W-1:0]      out_data_reg;
    logic                            out_hit_reg;

    logic [dmc_pkg::TAG_W-1:0]       tag_reg [dmc_pkg::NUM_LINES];
    logic [dmc_pkg::NUM_LINES-1:0]   valid_reg;
    logic [dmc_pkg::NUM_LINES-1:0]   dirty_reg;
    dmc_pkg::block_t                 cache_reg [dmc_pkg::NUM_LINES];
    dmc_pkg::block_t                 crow_reg;

    logic                            start;
    logic                            exec;
    logic                            is_write;
    logic [BIDX_W-1:0]               bidx;
    dmc_pkg::block_t                 base_row;
    dmc_pkg::block_t                 merged;
    logic [dmc_pkg::DATA_W-1:0]      rbyte;

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.hit       = out_hit_reg;

    // the response slot is free by the time the update cycle fills it
    assign start    = (state_reg == S_IDLE) && head_valid && (!out_valid_reg || rsp.ready);
    assign pop      = start;
    assign exec     = (state_reg == S_EXEC);
    assign is_write = (cur_reg.op == dmc_pkg::OP_WRITE);
    assign bidx     = {cur_reg.offset, {dmc_pkg::BYTE_SH_W{1'b0}}};

    // hit works on the cached row, a miss on the refill block
    always_comb
    begin
        base_row = hit_reg ? crow_reg : mem_rdata;
        merged   = base_row;
        if (is_write)
        begin
            merged[bidx +: dmc_pkg::DATA_W] = cur_reg.wdata;
        end
        rbyte = is_write ? '0 : base_row[bidx +: dmc_pkg::DATA_W];
    end

    always_comb
    begin
        mreq.rd     = start;
        mreq.rd_blk = {head.tag, head.line};
        mreq.wr     = exec && !hit_reg && victim_dirty_reg;
        mreq.wr_blk = {victim_tag_reg, cur_reg.line};
        mreq.wdata  = crow_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cur_reg          <= '0;
            hit_reg          <= 1'b0;
            victim_dirty_reg <= 1'b0;
            victim_tag_reg   <= '0;
            out_valid_reg    <= 1'b0;
            out_data_reg     <= '0;
            out_hit_reg      <= 1'b0;
        end
        else
        begin
            // the slot is always empty during the update cycle
            if (rsp.ready && !exec)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cur_reg          <= head;
                        hit_reg          <= valid_reg[head.line] && (tag_reg[head.line] == head.tag);
                        victim_dirty_reg <= dirty_reg[head.line];
                        victim_tag_reg   <= tag_reg[head.line];
                        state_reg        <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= rbyte;
                    out_hit_reg   <= hit_reg;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < dmc_pkg::NUM_LINES; i++)
            begin
                tag_reg[i] <= '0;
            end
            valid_reg <= '0;
            dirty_reg <= '0;
        end
        else if (exec)
        begin
            if (!hit_reg)
            begin
                tag_reg[cur_reg.line]   <= cur_reg.tag;
                valid_reg[cur_reg.line] <= 1'b1;
                dirty_reg[cur_reg.line] <= is_write;
            end
            else if (is_write)
            begin
                dirty_reg[cur_reg.line] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            crow_reg <= cache_reg[head.line];
        end
        if (exec && (!hit_reg || is_write))
        begin
            cache_reg[cur_reg.line] <= merged;
        end
    end

endmodule

// File: sv/direct_mapped_write_back_cache.sv
// Direct-mapped write-back cache of 16 lines of 16 bytes in front of a 2048-byte backing
// memory. Each request beat is a byte read or write; each gives one response beat with the
// byte read (zero on writes) and a hit flag. Requests are decoded into a two-entry queue, so
// the request side keeps accepting while the cache works, until the queue is full. Every
// request, hit or miss, first does registered reads of the tag entry, the line store row and
// the backing memory block, and then an update step in which, on a miss, a dirty victim
// block is written back whole and the refill block is written whole, and the byte is
// accessed. Backing memory blocks never written back read as their power-on pattern (each
// byte equal to its address mod 256), so there is no clearing pass after reset.
module direct_mapped_write_back_cache (
    input  logic       clk,
    input  logic       rst_n,
    dmc_req_if.sink    in,
    dmc_rsp_if.source  out
);

    dmc_pkg::req_t     head;
    logic              head_valid;
    logic              pop;
    dmc_pkg::mem_req_t mreq;
    dmc_pkg::block_t   mem_rdata;

    dmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (in),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    dmc_mem u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .mreq  (mreq),
        .rdata (mem_rdata)
    );

    dmc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .mreq       (mreq),
        .mem_rdata  (mem_rdata),
        .rsp        (out)
    );

endmodule

// File: sim/testbench.sv
// self-checking testbench for the direct-mapped write-back cache
module testbench;

    localparam logic HIT  = 1'b1;
    localparam logic MISS = 1'b0;

    localparam int RANDOM_PER_PHASE = 465;
    localparam int PRESSURE_BEATS   = 60;
    localparam int HOLD_CYCLES      = 400;
    localparam int TAIL_CYCLES      = 20;
    localparam int MAX_REPORTS      = 10;

    localparam int SEND_IDLE_PCT[4]  = '{0, 82, 0, 29};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 82, 29};

    typedef struct packed {
        logic [dmc_pkg::DATA_W-1:0] read_data;
        logic                       hit;
    } cache_rsp_t;

    typedef struct packed {
        logic                       op;
        logic [dmc_pkg::ADDR_W-1:0] address;
        logic [dmc_pkg::DATA_W-1:0] write_data;
        logic                       typed;
        logic [dmc_pkg::DATA_W-1:0] want_data;
        logic                       want_hit;
    } dir_row_t;

    // typed rows follow from reset contents (byte = address mod 256) and the writes above them
    localparam dir_row_t DIR_ROWS[24] = '{
        '{dmc_pkg::OP_READ,  11'h000, 8'h00, 1'b1, 8'h00, MISS},
        '{dmc_pkg::OP_READ,  11'h7FF, 8'h00, 1'b1, 8'hFF, MISS},
        '{dmc_pkg::OP_READ,  11'h7FF, 8'h00, 1'b1, 8'hFF, HIT},
        '{dmc_pkg::OP_WRITE, 11'h7F0, 8'hFF, 1'b1, 8'h00, HIT},
        '{dmc_pkg::OP_WRITE, 11'h7F1, 8'h00, 1'b1, 8'h00, HIT},
        '{dmc_pkg::OP_READ,  11'h7F0, 8'h00, 1'b1, 8'hFF, HIT},
        '{dmc_pkg::OP_READ,  11'h0F0, 8'h00, 1'b1, 8'hF0, MISS},
        '{dmc_pkg::OP_READ,  11'h7F1, 8'h00, 1'b1, 8'h00, MISS},
        '{dmc_pkg::OP_READ,  11'h7F0, 8'h00, 1'b1, 8'hFF, HIT},
        '{dmc_pkg::OP_WRITE, 11'h123, 8'h55, 1'b1, 8'h00, MISS},
        '{dmc_pkg::OP_READ,  11'h123, 8'h00, 1'b1, 8'h55, HIT},
        '{dmc_pkg::OP_READ,  11'h023, 8'h00, 1'b1, 8'h23, MISS},
        '{dmc_pkg::OP_READ,  11'h123, 8'h00, 1'b1, 8'h55, MISS},
        '{dmc_pkg::OP_READ,  11'h223, 8'h00, 1'b1, 8'h23, MISS},
        '{dmc_pkg::OP_READ,  11'h123, 8'h00, 1'b1, 8'h55, MISS},
        '{dmc_pkg::OP_WRITE, 11'h00F, 8'hA5, 1'b1, 8'h00, HIT},
        '{dmc_pkg::OP_READ,  11'h000, 8'hFF, 1'b1, 8'h00, HIT},
        '{dmc_pkg::OP_READ,  11'h40F, 8'h00, 1'b1, 8'h0F, MISS},
        '{dmc_pkg::OP_READ,  11'h00F, 8'h00, 1'b1, 8'hA5, MISS},
        '{dmc_pkg::OP_WRITE, 11'h555, 8'h3C, 1'b0, 8'h00, MISS},
        '{dmc_pkg::OP_READ,  11'h555, 8'h00, 1'b0, 8'h00, MISS},
        '{dmc_pkg::OP_WRITE, 11'h2AA, 8'hC3, 1'b0, 8'h00, MISS},
        '{dmc_pkg::OP_READ,  11'h6AA, 8'h00, 1'b0, 8'h00, MISS},
        '{dmc_pkg::OP_READ,  11'h2AA, 8'h00, 1'b0, 8'h00, MISS}
    };

    logic clk;
    logic rst_n;

    dmc_req_if req_ch ();
    dmc_rsp_if rsp_ch ();

    direct_mapped_write_back_cache dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (req_ch),
        .out   (rsp_ch)
    );

    // cache image kept by the testbench
    logic [dmc_pkg::DATA_W-1:0] mem_image  [0:(1<<dmc_pkg::ADDR_W)-1];
    logic [dmc_pkg::DATA_W-1:0] line_bytes [0:dmc_pkg::NUM_LINES-1][0:dmc_pkg::BLOCK_BYTES-1];
    logic [dmc_pkg::TAG_W-1:0]  line_tags  [0:dmc_pkg::NUM_LINES-1];
    logic                       line_live  [0:dmc_pkg::NUM_LINES-1];
    logic                       line_dirty [0:dmc_pkg::NUM_LINES-1];

    cache_rsp_t pending_rsp[$];
    cache_rsp_t head_rsp;
    int         mismatch_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    logic       start_hold;
    logic       hold_off;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic clear_cache_image();
        for (int a = 0; a < (1 << dmc_pkg::ADDR_W); a++)
        begin
            mem_image[a] = dmc_pkg::DATA_W'(a);
        end
        for (int l = 0; l < dmc_pkg::NUM_LINES; l++)
        begin
            line_tags[l]  = '0;
            line_live[l]  = 1'b0;
            line_dirty[l] = 1'b0;
            for (int b = 0; b < dmc_pkg::BLOCK_BYTES; b++)
            begin
                line_bytes[l][b] = '0;
            end
        end
    endtask

    function automatic cache_rsp_t cache_access(input logic op,
                                                input logic [dmc_pkg::ADDR_W-1:0] addr,
                                                input logic [dmc_pkg::DATA_W-1:0] wd);
        logic [dmc_pkg::TAG_W-1:0]  tg;
        logic [dmc_pkg::LINE_W-1:0] ln;
        logic [dmc_pkg::OFF_W-1:0]  off;
        cache_rsp_t                 r;
        tg  = addr[dmc_pkg::ADDR_W-1:dmc_pkg::LINE_W+dmc_pkg::OFF_W];
        ln  = addr[dmc_pkg::LINE_W+dmc_pkg::OFF_W-1:dmc_pkg::OFF_W];
        off = addr[dmc_pkg::OFF_W-1:0];
        r.hit = line_live[ln] && line_tags[ln] == tg;
        r.read_data = '0;
        if (!r.hit)
        begin
            // victim goes back to its own block before the refill
            if (line_dirty[ln])
            begin
                for (int b = 0; b < dmc_pkg::BLOCK_BYTES; b++)
                begin
                    mem_image[{line_tags[ln], ln, dmc_pkg::OFF_W'(b)}] = line_bytes[ln][b];
                end
                line_dirty[ln] = 1'b0;
            end
            for (int b = 0; b < dmc_pkg::BLOCK_BYTES; b++)
            begin
                line_bytes[ln][b] = mem_image[{tg, ln, dmc_pkg::OFF_W'(b)}];
            end
            line_live[ln] = 1'b1;
            line_tags[ln] = tg;
        end
        if (op == dmc_pkg::OP_WRITE)
        begin
            line_bytes[ln][off] = wd;
            line_dirty[ln] = 1'b1;
        end
        else
        begin
            r.read_data = line_bytes[ln][off];
        end
        return r;
    endfunction

    // mostly a few hot tags and the previous block, so hits and dirty evictions are common
    function automatic logic [dmc_pkg::ADDR_W-1:0] next_address(
        input logic [dmc_pkg::ADDR_W-1:0] prev);
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 4)
        begin
            return {dmc_pkg::TAG_W'($urandom_range(0, 1)), dmc_pkg::LINE_W'($urandom),
                    dmc_pkg::OFF_W'($urandom)};
        end
        else if (mode < 7)
        begin
            return {prev[dmc_pkg::ADDR_W-1:dmc_pkg::OFF_W], dmc_pkg::OFF_W'($urandom)};
        end
        return dmc_pkg::ADDR_W'($urandom);
    endfunction

    task automatic offer(input logic op, input logic [dmc_pkg::ADDR_W-1:0] addr,
                         input logic [dmc_pkg::DATA_W-1:0] wd, input logic typed,
                         input cache_rsp_t typed_rsp);
        cache_rsp_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.address    <= addr;
        req_ch.write_data <= wd;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = cache_access(op, addr, wd);
        pending_rsp.push_back(typed ? typed_rsp : predicted);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_rsp.size() != 0);
    endtask

    // response side: random stalls, plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        hold_off = 1'b0;
        wait (start_hold === 1'b1);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                    $display("unexpected response beat: read_data %02h hit %0b",
                             rsp_ch.read_data, rsp_ch.hit);
                mismatch_count++;
            end
            else
            begin
                head_rsp = pending_rsp.pop_front();
                if (rsp_ch.read_data !== head_rsp.read_data || rsp_ch.hit !== head_rsp.hit)
                begin
                    if (mismatch_count < MAX_REPORTS)
                        $display("mismatch: read_data exp %02h got %02h, hit exp %0b got %0b",
                                 head_rsp.read_data, rsp_ch.read_data,
                                 head_rsp.hit, rsp_ch.hit);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("FAIL direct_mapped_write_back_cache");
        $finish;
    end

    initial
    begin
        logic [dmc_pkg::ADDR_W-1:0] addr;
        logic [dmc_pkg::ADDR_W-1:0] prev_addr;
        cache_rsp_t                 typed_rsp;
        mismatch_count    = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        start_hold        = 1'b0;
        prev_addr         = '0;
        rst_n             <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= dmc_pkg::OP_READ;
        req_ch.address    <= '0;
        req_ch.write_data <= '0;
        clear_cache_image();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIR_ROWS[k])
        begin
            typed_rsp = '{DIR_ROWS[k].want_data, DIR_ROWS[k].want_hit};
            offer(DIR_ROWS[k].op, DIR_ROWS[k].address, DIR_ROWS[k].write_data,
                  DIR_ROWS[k].typed, typed_rsp);
        end
        drain();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = SEND_IDLE_PCT[p];
            recv_stall_pct = RECV_STALL_PCT[p];
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                addr = next_address(prev_addr);
                prev_addr = addr;
                offer(1'($urandom), addr, dmc_pkg::DATA_W'($urandom), 1'b0, '0);
            end
            drain();
        end

        // response side held off while requests keep coming, so the block backs up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        start_hold     = 1'b1;
        for (int k = 0; k < PRESSURE_BEATS; k++)
        begin
            addr = next_address(prev_addr);
            prev_addr = addr;
            offer(1'($urandom), addr, dmc_pkg::DATA_W'($urandom), 1'b0, '0);
        end
        drain();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASS direct_mapped_write_back_cache");
        else
            $display("FAIL direct_mapped_write_back_cache");
        $finish;
    end

endmodule
